// ===== hw/rtl/euler_to_quaternion_assert.svh =====
// Assertion macros for the Euler angle to quaternion converter.
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH

// Property that holds in the same cycle as its antecedent.
`define E2Q_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion name failed");

// Property that holds in the cycle after its antecedent.
`define E2Q_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion name failed");

`endif

// ===== hw/rtl/e2q_pkg.sv =====
// Types, constants and arithmetic helpers shared by the converter modules.
package e2q_pkg;

   localparam int ANG_W = 16;
   localparam int XY_W = 33;
   localparam int Z_W = 32;
   localparam int CS_W = 32;
   localparam int Q_W = 9;
   localparam int R_W = 6;
   localparam int ZQ_W = 23;
   localparam int ZR_W = 14;
   localparam int R_DEPTH = 45;

   localparam longint HalfPiQ30 = 64'd1686629713;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam longint QuarterTurn = 64'd11520;
   localparam logic signed [16:0] QUARTER_TURN = 17'sd11520;
   localparam logic signed [16:0] HALF_TURN = 17'sd23040;
   localparam logic signed [16:0] FULL_TURN = 17'sd46080;
   localparam logic [14:0] RECIP_45 = 15'd23302;
   localparam logic [5:0] DIV_45 = 6'd45;
   localparam logic [14:0] QUARTER_CMP = 15'd11520;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } rot_type;

   typedef struct packed {
      rot_type [2:0] rot;
      logic [2:0]    flip;
   } lane_type;

   typedef logic [31:0] atan_arr_type [32];
   typedef logic [ZQ_W-1:0] zq_arr_type [R_DEPTH];
   typedef logic [ZR_W-1:0] zr_arr_type [R_DEPTH];

   localparam atan_arr_type ATAN_TABLE = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   function automatic zq_arr_type build_zq();
      zq_arr_type t;
      longint c;
      for (int r = 0; r < R_DEPTH; r++) begin
         c = longint'(r) * HalfPiQ30 + QuarterTurn / 2;
         t[r] = ZQ_W'(c / QuarterTurn);
      end
      return t;
   endfunction

   function automatic zr_arr_type build_zr();
      zr_arr_type t;
      longint c;
      for (int r = 0; r < R_DEPTH; r++) begin
         c = longint'(r) * HalfPiQ30 + QuarterTurn / 2;
         t[r] = ZR_W'(c % QuarterTurn);
      end
      return t;
   endfunction

   localparam zq_arr_type ZQ_TABLE = build_zq();
   localparam zr_arr_type ZR_TABLE = build_zr();

   function automatic logic signed [CS_W-1:0] mul30(input logic signed [CS_W-1:0] a,
                                                   input logic signed [CS_W-1:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + 64'sd536870912;
      return CS_W'(p >>> 30);
   endfunction

endpackage

// ===== hw/rtl/e2q_prep.sv =====
// Angle wrap and conversion of the half angles to Q30 radians.
module e2q_prep
   import e2q_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [3*ANG_W-1:0]     in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output lane_type               out_lane
);

   typedef struct packed {
      logic [Q_W-1:0] q;
      logic [R_W-1:0] r;
      logic           neg;
      logic           flip;
   } prep_type;

   prep_type [2:0] a_in, a_ff;
   logic           va_ff, vb_ff;
   logic           rdy_a, rdy_b;
   lane_type       b_in, b_ff;

   assign rdy_b = !vb_ff || out_ready;
   assign rdy_a = !va_ff || rdy_b;
   assign in_ready = rdy_a;
   assign out_valid = vb_ff;
   assign out_lane = b_ff;

   always_comb begin
      logic signed [16:0] t;
      logic [13:0]        mag;
      logic [28:0]        p;
      logic [13:0]        rem;
      for (int k = 0; k < 3; k++) begin
         t = 17'(signed'(in_data[k*ANG_W +: ANG_W]));
         a_in[k].flip = 1'b0;
         if (t > HALF_TURN) t = t - FULL_TURN;
         if (t < -HALF_TURN) t = t + FULL_TURN;
         if (t > QUARTER_TURN) begin
            t = t - HALF_TURN;
            a_in[k].flip = 1'b1;
         end
         if (t < -QUARTER_TURN) begin
            t = t + HALF_TURN;
            a_in[k].flip = 1'b1;
         end
         a_in[k].neg = t[16];
         mag = t[16] ? 14'(-t) : 14'(t);
         p = 29'(mag) * 29'(RECIP_45);
         a_in[k].q = p[28:20];
         rem = mag - 14'(a_in[k].q) * 14'(DIV_45);
         a_in[k].r = rem[R_W-1:0];
      end
   end

   always_comb begin
      logic [39:0]     qh;
      logic [14:0]     frac;
      logic [30:0]     zmag;
      for (int k = 0; k < 3; k++) begin
         qh = 40'(a_ff[k].q) * 40'(HALF_PI_Q30);
         frac = 15'(qh[7:0]) * 15'(DIV_45) + 15'(ZR_TABLE[a_ff[k].r]);
         zmag = qh[38:8] + 31'(ZQ_TABLE[a_ff[k].r]) + 31'(frac >= QUARTER_CMP);
         b_in.rot[k].x = CORDIC_GAIN;
         b_in.rot[k].y = '0;
         b_in.rot[k].z = a_ff[k].neg ? -Z_W'(zmag) : Z_W'(zmag);
         b_in.flip[k] = a_ff[k].flip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= in_valid;
         if (rdy_b) vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a && in_valid) a_ff <= a_in;
      if (rdy_b && va_ff) b_ff <= b_in;
   end

endmodule

// ===== hw/rtl/e2q_cell.sv =====
// One CORDIC rotation step applied to all three angles.
module e2q_cell
   import e2q_pkg::*;
#(
   parameter int STEP = 0
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  lane_type in_lane,
   output logic     out_valid,
   input  logic     out_ready,
   output lane_type out_lane
);

   localparam logic signed [Z_W-1:0] ATAN_STEP = Z_W'(signed'(ATAN_TABLE[STEP]));

   logic     valid_ff;
   lane_type lane_in, lane_ff;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_lane = lane_ff;

   always_comb begin
      logic signed [XY_W-1:0] dx, dy;
      lane_in.flip = in_lane.flip;
      for (int k = 0; k < 3; k++) begin
         dx = in_lane.rot[k].y >>> STEP;
         dy = in_lane.rot[k].x >>> STEP;
         if (!in_lane.rot[k].z[Z_W-1]) begin
            lane_in.rot[k].x = in_lane.rot[k].x - dx;
            lane_in.rot[k].y = in_lane.rot[k].y + dy;
            lane_in.rot[k].z = in_lane.rot[k].z - ATAN_STEP;
         end else begin
            lane_in.rot[k].x = in_lane.rot[k].x + dx;
            lane_in.rot[k].y = in_lane.rot[k].y - dy;
            lane_in.rot[k].z = in_lane.rot[k].z + ATAN_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) lane_ff <= lane_in;
   end

endmodule

// ===== hw/rtl/e2q_combine.sv =====
// Quaternion products, rounding and saturation with the output register.
module e2q_combine
   import e2q_pkg::*;
#(
   parameter int OUT_WIDTH = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  lane_type               in_lane,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [4*OUT_WIDTH-1:0] out_quat
);

   localparam int SH = 31 - OUT_WIDTH;
   localparam int SHP = (SH > 0) ? SH : 1;
   localparam logic signed [34:0] LIM = 35'((64'sd1 <<< (OUT_WIDTH - 1)) - 64'sd1);
   localparam logic signed [34:0] RND = 35'sd1 <<< (SHP - 1);

   logic signed [CS_W-1:0] c_in [3], s_in [3];
   logic signed [CS_W-1:0] p1_in [6], p1_ff [6];
   logic signed [CS_W-1:0] p2_in [8], p2_ff [8];
   logic [4*OUT_WIDTH-1:0] q_in, q_ff;
   logic                   v1_ff, v2_ff, v3_ff;
   logic                   rdy1, rdy2, rdy3;

   assign rdy3 = !v3_ff || out_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign in_ready = rdy1;
   assign out_valid = v3_ff;
   assign out_quat = q_ff;

   function automatic logic [OUT_WIDTH-1:0] to_out(input logic signed [CS_W:0] v);
      logic signed [34:0] e, r;
      e = 35'(v);
      if (SH > 0) r = (e + RND) >>> SHP;
      else if (SH == 0) r = e;
      else r = e <<< 1;
      if (r > LIM) r = LIM;
      if (r < -LIM) r = -LIM;
      return r[OUT_WIDTH-1:0];
   endfunction

   always_comb begin
      logic signed [XY_W-1:0] cx, sy;
      for (int k = 0; k < 3; k++) begin
         cx = in_lane.flip[k] ? -in_lane.rot[k].x : in_lane.rot[k].x;
         sy = in_lane.flip[k] ? -in_lane.rot[k].y : in_lane.rot[k].y;
         c_in[k] = cx[CS_W-1:0];
         s_in[k] = sy[CS_W-1:0];
      end
      p1_in[0] = mul30(c_in[0], c_in[1]);
      p1_in[1] = mul30(s_in[0], s_in[1]);
      p1_in[2] = mul30(s_in[0], c_in[1]);
      p1_in[3] = mul30(c_in[0], s_in[1]);
      p1_in[4] = c_in[2];
      p1_in[5] = s_in[2];
   end

   always_comb begin
      p2_in[0] = mul30(p1_ff[0], p1_ff[4]);
      p2_in[1] = mul30(p1_ff[1], p1_ff[5]);
      p2_in[2] = mul30(p1_ff[0], p1_ff[5]);
      p2_in[3] = mul30(p1_ff[1], p1_ff[4]);
      p2_in[4] = mul30(p1_ff[2], p1_ff[4]);
      p2_in[5] = mul30(p1_ff[3], p1_ff[5]);
      p2_in[6] = mul30(p1_ff[3], p1_ff[4]);
      p2_in[7] = mul30(p1_ff[2], p1_ff[5]);
   end

   always_comb begin
      q_in[0*OUT_WIDTH +: OUT_WIDTH] = to_out(33'(p2_ff[0]) - 33'(p2_ff[1]));
      q_in[1*OUT_WIDTH +: OUT_WIDTH] = to_out(33'(p2_ff[2]) + 33'(p2_ff[3]));
      q_in[2*OUT_WIDTH +: OUT_WIDTH] = to_out(33'(p2_ff[4]) + 33'(p2_ff[5]));
      q_in[3*OUT_WIDTH +: OUT_WIDTH] = to_out(33'(p2_ff[6]) - 33'(p2_ff[7]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) p1_ff <= p1_in;
      if (rdy2 && v1_ff) p2_ff <= p2_in;
      if (rdy3 && v2_ff) q_ff <= q_in;
   end

endmodule

// ===== hw/rtl/euler_to_quaternion.sv =====
// Top level of the Euler angle to unit quaternion converter.
// The block takes one angle triple per clock while it is not stalled and returns one quaternion
// per triple, in order. Each word passes through the angle wrap and scaling registers, one
// rotation cell for each of the CORDIC_STEPS steps, and the product and rounding registers.
// Throughput is one word per cycle while the result side does not stall, set by the row of
// CORDIC cells that each hand their word on every cycle; a stall on the result side holds only
// the stages that are full.
module euler_to_quaternion
   import e2q_pkg::*;
#(
   parameter int OUT_WIDTH = 16,
   parameter int CORDIC_STEPS = 16
)
(
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // heading_deg [15:0], attitude_deg [31:16], bank_deg [47:32]
   input  logic [47:0]                             req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // quat_w, quat_x, quat_y, quat_z, each OUT_WIDTH bits, then zero fill
   output logic [((4*OUT_WIDTH+7)/8)*8-1:0]        rsp_tdata
);

   localparam int PAD = ((4*OUT_WIDTH+7)/8)*8 - 4*OUT_WIDTH;

   lane_type               lane [CORDIC_STEPS+1];
   logic                   valid [CORDIC_STEPS+1];
   logic                   ready [CORDIC_STEPS+1];
   logic [4*OUT_WIDTH-1:0] quat;

   e2q_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (valid[0]),
      .out_ready (ready[0]),
      .out_lane  (lane[0])
   );

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      e2q_cell #(.STEP(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[i]),
         .in_ready  (ready[i]),
         .in_lane   (lane[i]),
         .out_valid (valid[i+1]),
         .out_ready (ready[i+1]),
         .out_lane  (lane[i+1])
      );
   end

   e2q_combine #(.OUT_WIDTH(OUT_WIDTH)) u_combine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid[CORDIC_STEPS]),
      .in_ready  (ready[CORDIC_STEPS]),
      .in_lane   (lane[CORDIC_STEPS]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_quat  (quat)
   );

   if (PAD > 0) begin : g_pad
      assign rsp_tdata = {{PAD{1'b0}}, quat};
   end else begin : g_nopad
      assign rsp_tdata = quat;
   end

endmodule

// ===== hw/rtl/e2q_checker.sv =====
// Port-level checks for the converter and their binding to the top level.
`include "euler_to_quaternion_assert.svh"

module e2q_checker #(
   parameter int OUT_WIDTH = 16
)
(
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [47:0]                      req_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [((4*OUT_WIDTH+7)/8)*8-1:0] rsp_tdata
);

   localparam logic [OUT_WIDTH-1:0] MOST_NEG = {1'b1, {(OUT_WIDTH-1){1'b0}}};

   logic unused_ok;
   logic wx_ok, yz_ok;

   assign unused_ok = req_tvalid & req_tready & (^req_tdata);
   assign wx_ok = (rsp_tdata[OUT_WIDTH-1:0] != MOST_NEG)
      && (rsp_tdata[2*OUT_WIDTH-1:OUT_WIDTH] != MOST_NEG);
   assign yz_ok = (rsp_tdata[3*OUT_WIDTH-1:2*OUT_WIDTH] != MOST_NEG)
      && (rsp_tdata[4*OUT_WIDTH-1:3*OUT_WIDTH] != MOST_NEG);

   `E2Q_ASSERT_NEXT(rsp_hold_a, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `E2Q_ASSERT_IMPL(rsp_after_reset_a, rsp_tvalid, !$past(reset))
   `E2Q_ASSERT_IMPL(sat_wx_a, rsp_tvalid, wx_ok)
   `E2Q_ASSERT_IMPL(sat_yz_a, rsp_tvalid, yz_ok)

endmodule

bind euler_to_quaternion e2q_checker #(.OUT_WIDTH(OUT_WIDTH)) u_e2q_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
